>>> rtl/sks_pkg.sv
// shared types and constants of the scalar kalman smoother
package sks_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 32;
    localparam int Q_W      = 17;
    localparam int WHOLE_W  = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_ERR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ERR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q        = 2'd2;

    // register values after reset
    localparam logic [ERR_W-1:0] MEAS_ERR_RST = 32'd131072;
    localparam logic [ERR_W-1:0] INIT_ERR_RST = 32'd131072;
    localparam logic [Q_W-1:0]   Q_RST        = 17'd655;

    // operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_STEP  = 2'd0,
        MUL_KEEP  = 2'd1,
        MUL_NOISE = 2'd2
    } t_mul_op;

endpackage

>>> rtl/sks_in_if.sv
// input channel carrying one sample word
interface sks_in_if;
    logic                       valid;
    logic                       ready;
    logic [sks_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/sks_out_if.sv
// output channel carrying one filter result word
interface sks_out_if;
    logic                        valid;
    logic                        ready;
    logic [sks_pkg::ERR_W-1:0]   estimate_fixed;
    logic [sks_pkg::WHOLE_W-1:0] estimate_whole;
    logic [sks_pkg::Q_W-1:0]     gain_now;
    logic [sks_pkg::ERR_W-1:0]   error_now;

    modport source (output valid, output estimate_fixed, output estimate_whole,
                    output gain_now, output error_now, input ready);
    modport sink   (input valid, input estimate_fixed, input estimate_whole,
                    input gain_now, input error_now, output ready);
endinterface

>>> rtl/sks_div.sv
// restoring divider producing the gain one quotient bit per cycle
module sks_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sks_pkg::ERR_W-1:0]     i_err,
    input  logic [sks_pkg::ERR_W:0]       i_sum,
    output logic                          o_done,
    output logic [FRAC_BITS:0]            o_quot
);
    localparam int QW    = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int REM_W = sks_pkg::ERR_W + 2;

    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;
    logic [REM_W-1:0]           r_rem;
    logic [QW-1:0]              r_quot;
    logic [sks_pkg::ERR_W:0]    r_div;
    logic                       r_lsb;

    logic [REM_W-1:0]           rem_sh;
    logic                       q_bit;
    logic [REM_W-1:0]           n_rem;

    // shift in the next dividend bit, the dividend is err << FRAC_BITS
    always_comb begin
        rem_sh = {r_rem[REM_W-2:0], (r_cnt == CNT_W'(QW)) ? r_lsb : 1'b0};
        q_bit  = (rem_sh >= {1'b0, r_div});
        n_rem  = q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
    end

    // iteration control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= CNT_W'(QW);
                r_rem  <= {3'b000, i_err[sks_pkg::ERR_W-1:1]};
                r_lsb  <= i_err[0];
                r_div  <= i_sum;
                r_quot <= '0;
            end else if (r_cnt != '0) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[QW-2:0], q_bit};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/sks_mul.sv
// shared multiplier with operand selection and registered product
module sks_mul #(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  sks_pkg::t_mul_op                   i_op,
    input  logic [SAMPLE_BITS+FRAC_BITS-1:0]   i_diff,
    input  logic [SAMPLE_BITS+FRAC_BITS-1:0]   i_step,
    input  logic [sks_pkg::ERR_W-1:0]          i_err,
    input  logic [FRAC_BITS:0]                 i_gain,
    input  logic [sks_pkg::Q_W-1:0]            i_q,
    output logic [((SAMPLE_BITS+FRAC_BITS > sks_pkg::ERR_W) ? SAMPLE_BITS+FRAC_BITS
                  : sks_pkg::ERR_W) + ((FRAC_BITS+1 > sks_pkg::Q_W) ? FRAC_BITS+1
                  : sks_pkg::Q_W) - 1:0]       o_prod
);
    localparam int EST_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int GAIN_W = FRAC_BITS + 1;
    localparam int MA_W   = (EST_W > sks_pkg::ERR_W) ? EST_W : sks_pkg::ERR_W;
    localparam int MB_W   = (GAIN_W > sks_pkg::Q_W) ? GAIN_W : sks_pkg::Q_W;
    localparam int P_W    = MA_W + MB_W;
    localparam logic [GAIN_W-1:0] ONE = GAIN_W'(1) << FRAC_BITS;

    logic [MA_W-1:0] op_a;
    logic [MB_W-1:0] op_b;
    logic [P_W-1:0]  r_prod;

    // operand selection
    always_comb begin
        case (i_op)
            sks_pkg::MUL_STEP: begin
                op_a = MA_W'(i_diff);
                op_b = MB_W'(i_gain);
            end
            sks_pkg::MUL_KEEP: begin
                op_a = MA_W'(i_err);
                op_b = MB_W'(ONE - i_gain);
            end
            sks_pkg::MUL_NOISE: begin
                op_a = MA_W'(i_step);
                op_b = MB_W'(i_q);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(op_a) * P_W'(op_b);
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/scalar_kalman_smoother_unit.sv
// scalar kalman smoother: sequencer, filter state and result register
// One sample word is filtered at a time. After acceptance the gain
// E / (E + M) is formed by a restoring divider, one quotient bit per cycle,
// and then a single shared multiplier is used three times in a row (gain
// times distance, one minus gain times error, step times process noise)
// before the new estimate and error are written back. A word is accepted
// only in the idle state, which is entered again after the write-back;
// the result sits in an output register, so the next sample may be taken
// while the previous result still waits. Configuration writes are accepted
// in any cycle and must only happen while the block is idle; writing the
// initial estimate error also reloads the running error.
module scalar_kalman_smoother_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sks_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sks_pkg::ERR_W-1:0]         i_cfg_data,
    sks_in_if.sink                            i_in,
    sks_out_if.source                         o_out
);
    localparam int EST_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int GAIN_W = FRAC_BITS + 1;
    localparam int SW     = (SAMPLE_BITS < sks_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                              : sks_pkg::SAMPLE_W;
    localparam int MA_W   = (EST_W > sks_pkg::ERR_W) ? EST_W : sks_pkg::ERR_W;
    localparam int MB_W   = (GAIN_W > sks_pkg::Q_W) ? GAIN_W : sks_pkg::Q_W;
    localparam int P_W    = MA_W + MB_W;
    localparam int PF_W   = P_W - FRAC_BITS;
    localparam int ES_W   = PF_W + 1;
    localparam logic [GAIN_W-1:0] ONE = GAIN_W'(1) << FRAC_BITS;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_MSTEP  = 6'b000100,
        ST_MKEEP  = 6'b001000,
        ST_MNOISE = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration and filter state
    logic [sks_pkg::ERR_W-1:0] r_meas_err;
    logic [sks_pkg::Q_W-1:0]   r_q;
    logic [EST_W-1:0]          r_est;
    logic [sks_pkg::ERR_W-1:0] r_err;

    // per-word working registers
    logic [EST_W-1:0]          r_diff;
    logic                      r_up;
    logic                      r_sum_zero;
    logic [GAIN_W-1:0]         r_gain;
    logic [EST_W-1:0]          r_step;
    logic [sks_pkg::ERR_W-1:0] r_term1;

    // result register
    logic                      r_out_valid;
    logic [EST_W-1:0]          r_out_est;
    logic [GAIN_W-1:0]         r_out_gain;
    logic [sks_pkg::ERR_W-1:0] r_out_err;

    logic                      accept;
    logic                      out_free;
    logic [EST_W-1:0]          meas;
    logic                      meas_up;
    logic [sks_pkg::ERR_W:0]   sum;
    logic                      div_done;
    logic [GAIN_W-1:0]         quot;
    sks_pkg::t_mul_op          mul_op;
    logic [P_W-1:0]            prod;
    logic [PF_W-1:0]           prod_frac;
    logic [ES_W-1:0]           err_sum;
    logic [sks_pkg::ERR_W-1:0] err_sat;
    logic [EST_W-1:0]          est_new;

    // handshakes
    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;

    // measurement, direction and divisor of the incoming word
    assign meas    = EST_W'(i_in.sample[SW-1:0]) << FRAC_BITS;
    assign meas_up = (meas >= r_est);
    assign sum     = {1'b0, r_err} + {1'b0, r_meas_err};

    sks_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_err   (r_err),
        .i_sum   (sum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // multiplier operand choice follows the sequencer
    always_comb begin
        case (r_state)
            ST_MSTEP: mul_op = sks_pkg::MUL_STEP;
            ST_MKEEP: mul_op = sks_pkg::MUL_KEEP;
            default:  mul_op = sks_pkg::MUL_NOISE;
        endcase
    end

    sks_mul #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .i_diff (r_diff),
        .i_step (r_step),
        .i_err  (r_err),
        .i_gain (r_gain),
        .i_q    (r_q),
        .o_prod (prod)
    );

    // product scaled back by one, error sum with saturation, new estimate
    assign prod_frac = prod[P_W-1:FRAC_BITS];
    assign err_sum   = ES_W'(r_term1) + ES_W'(prod_frac);
    assign err_sat   = (|err_sum[ES_W-1:sks_pkg::ERR_W]) ? '1
                                                         : err_sum[sks_pkg::ERR_W-1:0];
    assign est_new   = r_up ? (r_est + r_step) : (r_est - r_step);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (accept) n_state = ST_DIV;
            ST_DIV:    if (div_done) n_state = ST_MSTEP;
            ST_MSTEP:  n_state = ST_MKEEP;
            ST_MKEEP:  n_state = ST_MNOISE;
            ST_MNOISE: n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_err <= sks_pkg::MEAS_ERR_RST;
            r_q        <= sks_pkg::Q_RST;
            r_err      <= sks_pkg::INIT_ERR_RST;
            r_est      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sks_pkg::CFG_MEAS_ERR: r_meas_err <= i_cfg_data;
                sks_pkg::CFG_INIT_ERR: r_err <= i_cfg_data;
                sks_pkg::CFG_Q:        r_q <= i_cfg_data[sks_pkg::Q_W-1:0];
                default: ;
            endcase
        end else if (r_state == ST_DONE && out_free) begin
            r_est <= est_new;
            r_err <= err_sat;
        end
    end

    // per-word working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up       <= meas_up;
            r_diff     <= meas_up ? (meas - r_est) : (r_est - meas);
            r_sum_zero <= (sum == '0);
        end
        if (r_state == ST_DIV && div_done) begin
            if (r_sum_zero) begin
                r_gain <= '0;
            end else if (quot > ONE) begin
                r_gain <= ONE;
            end else begin
                r_gain <= quot;
            end
        end
        if (r_state == ST_MKEEP) begin
            r_step <= EST_W'(prod_frac);
        end
        if (r_state == ST_MNOISE) begin
            r_term1 <= sks_pkg::ERR_W'(prod_frac);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_est  <= est_new;
            r_out_gain <= r_gain;
            r_out_err  <= err_sat;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.estimate_fixed = sks_pkg::ERR_W'(r_out_est);
    assign o_out.estimate_whole = sks_pkg::WHOLE_W'(r_out_est >> FRAC_BITS);
    assign o_out.gain_now       = sks_pkg::Q_W'(r_out_gain);
    assign o_out.error_now      = r_out_err;

endmodule
